FILE: hdl/tvs_pkg.sv
// ============================================================================
// tvs_pkg: shared types and constants for the trilinear voxel sampler
// Grid geometry, voxel bank layout, register indexes and operation codes.
// ============================================================================
package tvs_pkg;

    // Grid size per axis (powers of two, bank split on the low coordinate bit)
    localparam int GRID_X = 32;
    localparam int GRID_Y = 32;
    localparam int GRID_Z = 32;
    localparam int XW     = $clog2(GRID_X);
    localparam int YW     = $clog2(GRID_Y);
    localparam int ZW     = $clog2(GRID_Z);

    // Voxel store: 15-bit linear index, split into 8 parity banks
    localparam int IDX_W      = 15;
    localparam int DENS_W     = 16;
    localparam int NUM_BANKS  = 8;
    localparam int BANK_AW    = (XW - 1) + (YW - 1) + (ZW - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;

    // Coordinate and register widths
    localparam int COORD_W = 32;
    localparam int DIFF_W  = 34;
    localparam int PROD_W  = 65;
    localparam int CFG_AW  = 3;

    localparam logic [COORD_W-1:0] SCALE_RESET = 32'd2097152;

    // Configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_MIN_X   = 3'd0,
        CFG_MIN_Y   = 3'd1,
        CFG_MIN_Z   = 3'd2,
        CFG_SCALE_X = 3'd3,
        CFG_SCALE_Y = 3'd4,
        CFG_SCALE_Z = 3'd5
    } cfg_idx_t;

    // Input word operation codes
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

endpackage

FILE: hdl/tvs_ram.sv
// ============================================================================
// tvs_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ============================================================================
module tvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/trilinear_voxel_sampler.sv
// ============================================================================
// trilinear_voxel_sampler: trilinear sampling of a 3D density grid
// Seven-stage pipeline, eight parity-banked voxel memories, seven lerps.
// ============================================================================
// Usage:
//   Input words are taken at a clock edge with start high and busy low; busy
//   is always low, so one word may be issued every cycle. operation selects a
//   load (sample_value written at voxel_index) or a query (point_x/y/z, signed
//   Q16.16). A load gives no result. A query gives one result word on
//   density_out / outside_box, marked by result_valid for one cycle.
//   Results leave in issue order.
//   Throughput is one word per cycle: the eight neighbor reads go to eight
//   banks split by coordinate parity, so each bank sees one read per cycle.
//   Every voxel must be loaded before a query reads it.
//   Configuration: cfg_we writes cfg_data into register cfg_index at once
//   (0..2 box corner, 3..5 voxel scale); write only while no query is in
//   flight. Reset clears the pipeline valid bits and restores box corner 0
//   and scale 32.0; the voxel store is not cleared. The receiver cannot
//   stall, so the pipeline never holds.
// ============================================================================
module trilinear_voxel_sampler (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             operation,
    input  logic [tvs_pkg::IDX_W-1:0]        voxel_index,
    input  logic [tvs_pkg::DENS_W-1:0]       sample_value,
    input  logic signed [tvs_pkg::COORD_W-1:0] point_x,
    input  logic signed [tvs_pkg::COORD_W-1:0] point_y,
    input  logic signed [tvs_pkg::COORD_W-1:0] point_z,
    input  logic                             cfg_we,
    input  logic [tvs_pkg::CFG_AW-1:0]       cfg_index,
    input  logic [tvs_pkg::COORD_W-1:0]      cfg_data,
    output logic                             result_valid,
    output logic [tvs_pkg::DENS_W-1:0]       density_out,
    output logic                             outside_box
);

    import tvs_pkg::*;

    localparam int FRAC_W = 16;
    localparam int FW     = 7;

    // Rounded lerp: a + (b - a) * f, half up, 16-bit result
    function automatic logic [DENS_W-1:0] lerp16(
        input logic [FRAC_W-1:0] f,
        input logic [DENS_W-1:0] a,
        input logic [DENS_W-1:0] b
    );
        logic signed [DENS_W+1:0] diff;
        logic signed [34:0]       acc;
        diff = $signed({2'b00, b}) - $signed({2'b00, a});
        acc  = $signed({3'b000, a, 16'h0000}) + diff * $signed({1'b0, f})
             + 35'sd32768;
        return acc[31:16];
    endfunction

    // Configuration registers
    logic signed [COORD_W-1:0] box_min_reg [3];
    logic [COORD_W-1:0]        scale_reg   [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                box_min_reg[i] <= '0;
                scale_reg[i]   <= SCALE_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MIN_X:   box_min_reg[0] <= cfg_data;
                CFG_MIN_Y:   box_min_reg[1] <= cfg_data;
                CFG_MIN_Z:   box_min_reg[2] <= cfg_data;
                CFG_SCALE_X: scale_reg[0]   <= cfg_data;
                CFG_SCALE_Y: scale_reg[1]   <= cfg_data;
                CFG_SCALE_Z: scale_reg[2]   <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    logic signed [COORD_W-1:0] pt [3];
    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    localparam int GRID [3] = '{GRID_X, GRID_Y, GRID_Z};

    // Valid and operation bits per stage
    logic [7:1] v_reg;
    logic [3:1] op_reg;
    logic [6:3] out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[6:1], accept};
        end
    end

    // Stage 1: offset from box corner
    logic signed [DIFF_W-1:0] d1_reg [3];
    logic [IDX_W-1:0]         idx1_reg, idx2_reg;
    logic [DENS_W-1:0]        val1_reg, val2_reg;

    always_ff @(posedge clk)
    begin
        op_reg[1] <= operation;
        idx1_reg  <= voxel_index;
        val1_reg  <= sample_value;
        for (int i = 0; i < 3; i++)
        begin
            d1_reg[i] <= DIFF_W'(pt[i]) - DIFF_W'(box_min_reg[i]);
        end
    end

    // Stage 2: scale to voxel units, Q33.32
    logic [PROD_W-1:0] s2_reg [3];
    logic              neg2_reg;

    always_ff @(posedge clk)
    begin
        op_reg[2] <= op_reg[1];
        idx2_reg  <= idx1_reg;
        val2_reg  <= val1_reg;
        neg2_reg  <= d1_reg[0][DIFF_W-1] | d1_reg[1][DIFF_W-1] | d1_reg[2][DIFF_W-1];
        for (int i = 0; i < 3; i++)
        begin
            s2_reg[i] <= PROD_W'({32'h0, d1_reg[i][31:0]} * {32'h0, scale_reg[i]})
                       + (d1_reg[i][32] ? {1'b0, scale_reg[i], 32'h0} : '0);
        end
    end

    // Stage 3: box test, floor, clamp, bank addresses (combinational part)
    logic                  outside3;
    logic [FRAC_W-1:0]     frac3 [3];
    logic [XW-1:0]         c_lo [3];
    logic [XW-1:0]         c_hi [3];

    always_comb
    begin
        logic [38:0]   w;
        logic [FW-1:0] fw;
        outside3 = neg2_reg;
        for (int i = 0; i < 3; i++)
        begin
            if ((s2_reg[i][64:32] > 33'(GRID[i]))
                || ((s2_reg[i][64:32] == 33'(GRID[i])) && (s2_reg[i][31:0] != '0)))
            begin
                outside3 = 1'b1;
            end
            w        = s2_reg[i][38:0] + 39'h0080000000;
            fw       = w[38:32];
            frac3[i] = w[31:16];
            c_lo[i]  = (fw == '0) ? '0 : XW'(fw - 7'd1);
            c_hi[i]  = (fw >= FW'(GRID[i])) ? XW'(GRID[i] - 1) : XW'(fw);
        end
    end

    // Per-bank read addresses: pick the neighbor coordinate of matching parity
    logic [BANK_AW-1:0] raddr_next [NUM_BANKS];
    logic [BANK_AW-1:0] raddr_reg  [NUM_BANKS];
    logic [BANK_AW-1:0] waddr_reg;
    logic [DENS_W-1:0]  wdata_reg;
    logic [NUM_BANKS-1:0] we_reg;
    logic [2:0]         par_lo_reg, par_hi_reg;
    logic [FRAC_W-1:0]  f4_reg [3];
    logic [FRAC_W-1:0]  f3_reg [3];

    always_comb
    begin
        logic [XW-1:0] c [3];
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c[i] = (c_lo[i][0] == b[i]) ? c_lo[i] : c_hi[i];
            end
            raddr_next[b] = {c[2][ZW-1:1], c[1][YW-1:1], c[0][XW-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            we_reg <= '0;
        end
        else
        begin
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                we_reg[b] <= v_reg[2] && (op_t'(op_reg[2]) == OP_LOAD)
                          && ({idx2_reg[XW+YW], idx2_reg[XW], idx2_reg[0]} == 3'(b));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg[3]  <= op_reg[2];
        out_reg[3] <= outside3;
        waddr_reg  <= {idx2_reg[IDX_W-1:XW+YW+1], idx2_reg[XW+YW-1:XW+1],
                       idx2_reg[XW-1:1]};
        wdata_reg  <= val2_reg;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            raddr_reg[b] <= raddr_next[b];
        end
        for (int i = 0; i < 3; i++)
        begin
            f3_reg[i]     <= frac3[i];
            par_lo_reg[i] <= c_lo[i][0];
            par_hi_reg[i] <= c_hi[i][0];
        end
    end

    // Voxel banks, read data lands in stage 4
    logic [DENS_W-1:0] rdata [NUM_BANKS];

    for (genvar gb = 0; gb < NUM_BANKS; gb++)
    begin : g_bank
        tvs_ram #(
            .WIDTH (DENS_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (we_reg[gb]),
            .waddr (waddr_reg),
            .wdata (wdata_reg),
            .raddr (raddr_reg[gb]),
            .rdata (rdata[gb])
        );
    end

    // Stage 4: pass fractions and parities alongside the read
    logic [2:0] plo4_reg, phi4_reg;
    logic       q4_reg;

    always_ff @(posedge clk)
    begin
        q4_reg     <= (op_t'(op_reg[3]) == OP_QUERY);
        out_reg[4] <= out_reg[3];
        plo4_reg   <= par_lo_reg;
        phi4_reg   <= par_hi_reg;
        for (int i = 0; i < 3; i++)
        begin
            f4_reg[i] <= f3_reg[i];
        end
    end

    // Stage 5: route banks to corners, four lerps along x
    logic [DENS_W-1:0] corner [NUM_BANKS];
    logic [DENS_W-1:0] cx5_reg [4];
    logic [FRAC_W-1:0] fy5_reg, fz5_reg, fz6_reg;
    logic              q5_reg, q6_reg, q7_reg;

    always_comb
    begin
        logic [2:0] bank;
        for (int k = 0; k < NUM_BANKS; k++)
        begin
            bank[0]   = k[0] ? phi4_reg[0] : plo4_reg[0];
            bank[1]   = k[1] ? phi4_reg[1] : plo4_reg[1];
            bank[2]   = k[2] ? phi4_reg[2] : plo4_reg[2];
            corner[k] = rdata[bank];
        end
    end

    always_ff @(posedge clk)
    begin
        q5_reg     <= q4_reg;
        out_reg[5] <= out_reg[4];
        fy5_reg    <= f4_reg[1];
        fz5_reg    <= f4_reg[2];
        for (int j = 0; j < 4; j++)
        begin
            cx5_reg[j] <= lerp16(f4_reg[0], corner[2*j], corner[2*j+1]);
        end
    end

    // Stage 6: two lerps along y
    logic [DENS_W-1:0] cy6_reg [2];

    always_ff @(posedge clk)
    begin
        q6_reg     <= q5_reg;
        out_reg[6] <= out_reg[5];
        fz6_reg    <= fz5_reg;
        cy6_reg[0] <= lerp16(fy5_reg, cx5_reg[0], cx5_reg[1]);
        cy6_reg[1] <= lerp16(fy5_reg, cx5_reg[2], cx5_reg[3]);
    end

    // Stage 7: lerp along z, output word
    logic [DENS_W-1:0] dens7_reg;
    logic              outb7_reg;

    always_ff @(posedge clk)
    begin
        q7_reg    <= q6_reg;
        outb7_reg <= out_reg[6];
        dens7_reg <= out_reg[6] ? '0 : lerp16(fz6_reg, cy6_reg[0], cy6_reg[1]);
    end

    assign result_valid = v_reg[7] && q7_reg;
    assign density_out  = dens7_reg;
    assign outside_box  = outb7_reg;

endmodule
